// File: sv/pte_pkg.sv
// Shared types, codes and constants for the pheromone table roulette engine.
// No dependencies; pte_dp, pte_ctrl and the top level import this package.
package pte_pkg;

  localparam int DEF_NUM_BINS = 32;
  localparam int DEF_MAX_DIMS = 16;

  localparam int DATA_W    = 32;
  localparam int CFG_IDX_W = 3;
  localparam int DIMS_W    = 5;
  localparam int EVAP_W    = 16;
  localparam int MODE_W    = 2;
  localparam int DIM_W     = 4;
  localparam int BIN_W     = 5;

  // restoring divider: 48-bit dividend (scale << 16), 33-bit divisor
  localparam int NUM_W     = 48;
  localparam int DEN_W     = 33;
  localparam int DIV_STEPS = 48;

  localparam logic [MODE_W-1:0] MODE_CLEAR   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_SELECT  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_DEPOSIT = 2'd2;
  localparam logic [MODE_W-1:0] MODE_EVAP    = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_DIMS  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INIT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_EVAP  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SEED  = 3'd4;

  localparam logic [DIMS_W-1:0] RESET_DIMS  = 5'd1;
  localparam logic [DATA_W-1:0] RESET_LEVEL = 32'h0001_0000;
  localparam logic [DATA_W-1:0] RESET_SCALE = 32'h0001_0000;
  localparam logic [EVAP_W-1:0] RESET_EVAP  = 16'd58982;
  localparam logic [DATA_W-1:0] RESET_SEED  = 32'd1;

  typedef enum logic [1:0] {
    WS_RESET,
    WS_INIT,
    WS_EVAP,
    WS_DEP
  } wsrc_e;

  typedef struct packed {
    logic  seed_ld;
    logic  rng_step;
    logic  acc_clr;
    logic  sum_en;
    logic  mul_lo;
    logic  mul_hi;
    logic  cmp_en;
    logic  div_start;
    logic  div_step;
    logic  wr_en;
    wsrc_e wsrc;
  } cmd_t;

  typedef struct packed {
    logic sum_zero;
    logic hit;
    logic sat;
  } sts_t;

  function automatic logic [DATA_W-1:0] xorshift32(input logic [DATA_W-1:0] x);
    logic [DATA_W-1:0] a;
    logic [DATA_W-1:0] b;
    a = x ^ (x << 13);
    b = a ^ (a >> 17);
    return b ^ (b << 5);
  endfunction

endpackage

// File: sv/pte_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module pte_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 512
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// File: sv/pte_dp.sv
// Datapath: pheromone RAM, xorshift generator, row sum and running sum,
// wide roulette product, restoring divider and write-data mux.
// Depends on pte_pkg and pte_ram.
module pte_dp
  import pte_pkg::*;
#(
  parameter int NUM_BINS = DEF_NUM_BINS,
  parameter int MAX_DIMS = DEF_MAX_DIMS
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  cmd_t                                   cmd_i,
  input  logic [$clog2(NUM_BINS*MAX_DIMS)-1:0]   rd_addr_i,
  input  logic [$clog2(NUM_BINS*MAX_DIMS)-1:0]   wr_addr_i,
  input  logic [DATA_W-1:0]                      init_level_i,
  input  logic [DATA_W-1:0]                      dep_scale_i,
  input  logic [EVAP_W-1:0]                      evap_i,
  input  logic [DATA_W-1:0]                      seed_i,
  input  logic signed [DATA_W-1:0]               ant_fit_i,
  input  logic signed [DATA_W-1:0]               best_fit_i,
  output sts_t                                   sts_o
);

  localparam int DEPTH = NUM_BINS * MAX_DIMS;
  localparam int SUM_W = DATA_W + $clog2(NUM_BINS);
  localparam int HI_W  = SUM_W - DATA_W;
  localparam int L_W   = SUM_W + DATA_W;

  logic [DATA_W-1:0]        rd_data;
  logic [DATA_W-1:0]        wr_data;
  logic [DATA_W-1:0]        rng_q, rng_d;
  logic [SUM_W-1:0]         sum_q, cum_q;
  logic [2*DATA_W-1:0]      lo_q;
  logic [SUM_W-1:0]         hi_q;
  logic [SUM_W-1:0]         hi_prod;
  logic [L_W-1:0]           lhs_q;
  logic [L_W:0]             lhs_plus;
  logic [L_W:0]             cum_sh;
  logic [DATA_W:0]          diff;
  logic [DEN_W-1:0]         den_start;
  logic [DEN_W-1:0]         den_q;
  logic [DEN_W:0]           rem_q, rem_sh;
  logic [NUM_W-1:0]         quo_q;
  logic [DATA_W:0]          dep_sum;
  logic [DATA_W+EVAP_W-1:0] evap_prod;

  pte_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.wr_en),
    .waddr_i (wr_addr_i),
    .wdata_i (wr_data),
    .raddr_i (rd_addr_i),
    .rdata_o (rd_data)
  );

  // generator; a zero seed would lock it, so it loads as one
  always_comb begin
    rng_d = rng_q;
    if (cmd_i.seed_ld) begin
      rng_d = (seed_i == '0) ? DATA_W'(1) : seed_i;
    end else if (cmd_i.rng_step) begin
      rng_d = xorshift32(rng_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rng_q <= RESET_SEED;
    end else begin
      rng_q <= rng_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.acc_clr) begin
      sum_q <= '0;
      cum_q <= '0;
    end else begin
      if (cmd_i.sum_en) sum_q <= sum_q + SUM_W'(rd_data);
      if (cmd_i.cmp_en) cum_q <= cum_q + SUM_W'(rd_data);
    end
  end

  // rng * sum split into a 32x32 and a 32xHI_W product, combined next cycle
  assign hi_prod = SUM_W'(rng_q) * SUM_W'(sum_q[SUM_W-1:DATA_W]);

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_lo) begin
      lo_q <= {{DATA_W{1'b0}}, rng_q} * {{DATA_W{1'b0}}, sum_q[DATA_W-1:0]};
      hi_q <= hi_prod;
    end
    if (cmd_i.mul_hi) begin
      lhs_q <= L_W'(lo_q) + {hi_q[HI_W+DATA_W-1:0], {DATA_W{1'b0}}};
    end
  end

  // rng*S <= C*(2^32-1)  <=>  rng*S + C <= C << 32
  assign lhs_plus = {1'b0, lhs_q} + (L_W+1)'(cum_q);
  assign cum_sh   = {1'b0, cum_q, {DATA_W{1'b0}}};

  // divisor 65536 + max(ant - best, 0), difference taken exactly in 33 bits
  assign diff = {ant_fit_i[DATA_W-1], ant_fit_i} - {best_fit_i[DATA_W-1], best_fit_i};

  always_comb begin
    den_start = DEN_W'(32'h0001_0000);
    if (!diff[DATA_W] && (diff != '0)) begin
      den_start = DEN_W'(32'h0001_0000) + {1'b0, diff[DATA_W-1:0]};
    end
  end

  assign rem_sh = {rem_q[DEN_W-1:0], quo_q[NUM_W-1]};

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      den_q <= den_start;
      rem_q <= '0;
      quo_q <= {dep_scale_i, 16'h0000};
    end else if (cmd_i.div_step) begin
      if (rem_sh >= {1'b0, den_q}) begin
        rem_q <= rem_sh - {1'b0, den_q};
        quo_q <= {quo_q[NUM_W-2:0], 1'b1};
      end else begin
        rem_q <= rem_sh;
        quo_q <= {quo_q[NUM_W-2:0], 1'b0};
      end
    end
  end

  // divisor is at least 65536, so the quotient fits 32 bits
  assign dep_sum   = {1'b0, rd_data} + {1'b0, quo_q[DATA_W-1:0]};
  assign evap_prod = (DATA_W+EVAP_W)'(rd_data) * (DATA_W+EVAP_W)'(evap_i);

  always_comb begin
    case (cmd_i.wsrc)
      WS_RESET: wr_data = RESET_LEVEL;
      WS_INIT:  wr_data = init_level_i;
      WS_EVAP:  wr_data = evap_prod[DATA_W+EVAP_W-1:EVAP_W];
      WS_DEP:   wr_data = dep_sum[DATA_W] ? {DATA_W{1'b1}} : dep_sum[DATA_W-1:0];
      default:  wr_data = RESET_LEVEL;
    endcase
  end

  assign sts_o.sum_zero = (sum_q == '0);
  assign sts_o.hit      = (lhs_plus <= cum_sh);
  assign sts_o.sat      = dep_sum[DATA_W];

endmodule

// File: sv/pte_ctrl.sv
// Controller: state machine, sweep and row counters, read pipeline tags,
// RAM addressing and the output result register.
// Depends on pte_pkg.
module pte_ctrl
  import pte_pkg::*;
#(
  parameter int NUM_BINS = DEF_NUM_BINS,
  parameter int MAX_DIMS = DEF_MAX_DIMS
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic [MODE_W-1:0]                    mode_i,
  input  logic [DIM_W-1:0]                     dim_i,
  input  logic [BIN_W-1:0]                     bin_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic [BIN_W-1:0]                     chosen_bin_o,
  output logic                                 saturated_o,
  input  logic [DIMS_W-1:0]                    dims_in_use_i,
  output cmd_t                                 cmd_o,
  output logic [$clog2(NUM_BINS*MAX_DIMS)-1:0] rd_addr_o,
  output logic [$clog2(NUM_BINS*MAX_DIMS)-1:0] wr_addr_o,
  input  sts_t                                 sts_i
);

  localparam int DEPTH  = NUM_BINS * MAX_DIMS;
  localparam int AW     = $clog2(DEPTH);
  localparam int CNT_W  = ($clog2(DEPTH + 1) > 6) ? $clog2(DEPTH + 1) : 6;
  localparam int ACT_W  = $clog2(MAX_DIMS + 1);

  localparam logic [3:0] ST_INIT   = 4'd0;
  localparam logic [3:0] ST_IDLE   = 4'd1;
  localparam logic [3:0] ST_CLEAR  = 4'd2;
  localparam logic [3:0] ST_SUM    = 4'd3;
  localparam logic [3:0] ST_MUL_LO = 4'd4;
  localparam logic [3:0] ST_MUL_HI = 4'd5;
  localparam logic [3:0] ST_CMP    = 4'd6;
  localparam logic [3:0] ST_DIV    = 4'd7;
  localparam logic [3:0] ST_DEP_RD = 4'd8;
  localparam logic [3:0] ST_DEP_WR = 4'd9;
  localparam logic [3:0] ST_EVAP   = 4'd10;
  localparam logic [3:0] ST_DONE   = 4'd11;

  logic [3:0]       state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [CNT_W-1:0] lim_q, lim_d;
  logic [AW-1:0]    base_q, base_d;
  logic [BIN_W-1:0] bin_q, bin_d;
  logic             p1_v_q, p1_v_d, p2_v_q;
  logic [CNT_W-1:0] p1_cnt_q, p2_cnt_q;
  logic [BIN_W-1:0] pend_bin_q, pend_bin_d;
  logic             pend_sat_q, pend_sat_d;
  logic             mv_q, mv_d;
  logic [BIN_W-1:0] obin_q;
  logic             osat_q;
  logic             out_ld;
  logic [ACT_W-1:0] act;
  logic             dim_ok, bin_ok, issue;
  logic [AW-1:0]    flat_addr, row_addr, dep_addr, p1_addr;

  assign act = (int'(dims_in_use_i) > MAX_DIMS) ? ACT_W'(MAX_DIMS) : ACT_W'(dims_in_use_i);
  assign dim_ok = int'(dim_i) < int'(act);
  assign bin_ok = int'(bin_i) < NUM_BINS;
  assign issue  = cnt_q < lim_q;

  assign flat_addr = AW'(cnt_q);
  assign row_addr  = base_q + AW'(cnt_q);
  assign dep_addr  = base_q + AW'(bin_q);
  assign p1_addr   = AW'(p1_cnt_q);

  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    lim_d      = lim_q;
    base_d     = base_q;
    bin_d      = bin_q;
    pend_bin_d = pend_bin_q;
    pend_sat_d = pend_sat_q;
    p1_v_d     = 1'b0;
    out_ld     = 1'b0;
    cmd_o      = '0;
    cmd_o.wsrc = WS_RESET;
    rd_addr_o  = row_addr;
    wr_addr_o  = dep_addr;

    unique case (state_q)
      ST_INIT: begin
        if (issue) begin
          cmd_o.wr_en = 1'b1;
          wr_addr_o   = flat_addr;
          cnt_d       = cnt_q + 1'b1;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          pend_bin_d = '0;
          pend_sat_d = 1'b0;
          cnt_d      = '0;
          base_d     = AW'(int'(dim_i) * NUM_BINS);
          bin_d      = bin_i;
          unique case (mode_i)
            MODE_CLEAR: begin
              cmd_o.seed_ld = 1'b1;
              lim_d         = CNT_W'(DEPTH);
              state_d       = ST_CLEAR;
            end
            MODE_SELECT: begin
              if (dim_ok) begin
                cmd_o.rng_step = 1'b1;
                cmd_o.acc_clr  = 1'b1;
                lim_d          = CNT_W'(NUM_BINS);
                state_d        = ST_SUM;
              end else begin
                state_d = ST_DONE;
              end
            end
            MODE_DEPOSIT: begin
              if (dim_ok && bin_ok) begin
                cmd_o.div_start = 1'b1;
                state_d         = ST_DIV;
              end else begin
                state_d = ST_DONE;
              end
            end
            default: begin
              lim_d   = CNT_W'(int'(act) * NUM_BINS);
              state_d = ST_EVAP;
            end
          endcase
        end
      end
      ST_CLEAR: begin
        if (issue) begin
          cmd_o.wr_en = 1'b1;
          cmd_o.wsrc  = WS_INIT;
          wr_addr_o   = flat_addr;
          cnt_d       = cnt_q + 1'b1;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_EVAP: begin
        rd_addr_o = flat_addr;
        if (issue) begin
          p1_v_d = 1'b1;
          cnt_d  = cnt_q + 1'b1;
        end
        if (p1_v_q) begin
          cmd_o.wr_en = 1'b1;
          cmd_o.wsrc  = WS_EVAP;
          wr_addr_o   = p1_addr;
        end
        if (!issue && !p1_v_q) state_d = ST_DONE;
      end
      ST_SUM: begin
        if (issue) begin
          p1_v_d = 1'b1;
          cnt_d  = cnt_q + 1'b1;
        end
        cmd_o.sum_en = p1_v_q;
        if (!issue && !p1_v_q) begin
          if (sts_i.sum_zero) begin
            pend_bin_d = BIN_W'(NUM_BINS - 1);
            state_d    = ST_DONE;
          end else begin
            state_d = ST_MUL_LO;
          end
        end
      end
      ST_MUL_LO: begin
        cmd_o.mul_lo = 1'b1;
        state_d      = ST_MUL_HI;
      end
      ST_MUL_HI: begin
        cmd_o.mul_hi = 1'b1;
        cnt_d        = '0;
        state_d      = ST_CMP;
      end
      ST_CMP: begin
        // read, accumulate, compare: a bin's verdict follows its RAM read register and the running-sum register
        if (issue) begin
          p1_v_d = 1'b1;
          cnt_d  = cnt_q + 1'b1;
        end
        cmd_o.cmp_en = p1_v_q;
        if (p2_v_q) begin
          if (sts_i.hit) begin
            pend_bin_d = BIN_W'(p2_cnt_q);
            state_d    = ST_DONE;
          end else if (p2_cnt_q == lim_q - 1'b1) begin
            pend_bin_d = BIN_W'(NUM_BINS - 1);
            state_d    = ST_DONE;
          end
        end
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(DIV_STEPS - 1)) state_d = ST_DEP_RD;
      end
      ST_DEP_RD: begin
        rd_addr_o = dep_addr;
        state_d   = ST_DEP_WR;
      end
      ST_DEP_WR: begin
        cmd_o.wr_en = 1'b1;
        cmd_o.wsrc  = WS_DEP;
        pend_sat_d  = sts_i.sat;
        state_d     = ST_DONE;
      end
      ST_DONE: begin
        if (!mv_q || out_ready_i) begin
          out_ld  = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign mv_d = out_ld | (mv_q & ~out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
      cnt_q   <= '0;
      lim_q   <= CNT_W'(DEPTH);
      p1_v_q  <= 1'b0;
      p2_v_q  <= 1'b0;
      mv_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      lim_q   <= lim_d;
      p1_v_q  <= p1_v_d;
      p2_v_q  <= p1_v_q;
      mv_q    <= mv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    base_q     <= base_d;
    bin_q      <= bin_d;
    pend_bin_q <= pend_bin_d;
    pend_sat_q <= pend_sat_d;
    p1_cnt_q   <= cnt_q;
    p2_cnt_q   <= p1_cnt_q;
    if (out_ld) begin
      obin_q <= pend_bin_q;
      osat_q <= pend_sat_q;
    end
  end

  assign out_valid_o  = mv_q;
  assign chosen_bin_o = obin_q;
  assign saturated_o  = osat_q;

  a_no_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> !cmd_o.wr_en)
    else $error("RAM write while idle");

  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q != ST_IDLE))
    else $error("accepted item did not start work");

  a_cmp_tag_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CMP && p2_v_q) |-> (int'(p2_cnt_q) < NUM_BINS))
    else $error("compare stage past last bin");

  a_dep_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DEP_WR) |-> ($past(state_q) == ST_DEP_RD))
    else $error("deposit write without read");

  a_result_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ld |-> (!mv_q || out_ready_i))
    else $error("result overwritten before transfer");

endmodule

// File: sv/pheromone_table_roulette_engine.sv
// Top level of the pheromone table roulette engine: configuration registers,
// stream port unpacking, controller and datapath. Depends on pte_pkg,
// pte_ctrl, pte_dp (and pte_ram through pte_dp).
//
// Usage:
//   Commands enter on the s_axis stream, one result per command leaves on
//   m_axis. Modes: clear table and reload seed, select a bin by roulette,
//   deposit into one entry, evaporate all active rows.
//   Work per command, B = NUM_BINS:
//     select    two passes over the row through the RAM read port,
//               one pass only when the row sums to zero
//     deposit   48-step restoring divider, then read/modify/write
//     evaporate active_rows*B entries, one entry a cycle through the RAM
//     clear     MAX_DIMS*B writes, one write a cycle
//     inactive row or bin out of range: no table work, result only
//   One command is worked on at a time; the next is taken once the result sits in
//   the output register, even if the receiver has not taken it yet. If the receiver
//   stalls with a result still held, the next result waits in the controller.
//   After reset the table is filled with the reset level, one entry a cycle over
//   all MAX_DIMS*NUM_BINS entries (512 by default), while s_axis_tready stays low.
//   Configuration writes are taken at any time but belong to idle periods.
module pheromone_table_roulette_engine
  import pte_pkg::*;
#(
  parameter int NUM_BINS = DEF_NUM_BINS,
  parameter int MAX_DIMS = DEF_MAX_DIMS
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [DATA_W-1:0]    cfg_data_i,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // mode[1:0], dim_index[5:2], bin_index[10:6], ant_fitness[42:11],
  // best_cost[74:43], zero pad [79:75]
  input  logic [79:0]          s_axis_tdata,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // chosen_bin[4:0], saturated[5], zero pad [7:6]
  output logic [7:0]           m_axis_tdata
);

  logic [DIMS_W-1:0] dims_q;
  logic [DATA_W-1:0] init_q;
  logic [DATA_W-1:0] scale_q;
  logic [EVAP_W-1:0] evap_q;
  logic [DATA_W-1:0] seed_q;

  cmd_t                                 cmd;
  sts_t                                 sts;
  logic [$clog2(NUM_BINS*MAX_DIMS)-1:0] rd_addr, wr_addr;
  logic [BIN_W-1:0]                     chosen_bin;
  logic                                 saturated;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dims_q  <= RESET_DIMS;
      init_q  <= RESET_LEVEL;
      scale_q <= RESET_SCALE;
      evap_q  <= RESET_EVAP;
      seed_q  <= RESET_SEED;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_DIMS:  dims_q  <= cfg_data_i[DIMS_W-1:0];
        REG_INIT:  init_q  <= cfg_data_i;
        REG_SCALE: scale_q <= cfg_data_i;
        REG_EVAP:  evap_q  <= cfg_data_i[EVAP_W-1:0];
        REG_SEED:  seed_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  pte_ctrl #(
    .NUM_BINS (NUM_BINS),
    .MAX_DIMS (MAX_DIMS)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (s_axis_tvalid),
    .in_ready_o    (s_axis_tready),
    .mode_i        (s_axis_tdata[1:0]),
    .dim_i         (s_axis_tdata[5:2]),
    .bin_i         (s_axis_tdata[10:6]),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .chosen_bin_o  (chosen_bin),
    .saturated_o   (saturated),
    .dims_in_use_i (dims_q),
    .cmd_o         (cmd),
    .rd_addr_o     (rd_addr),
    .wr_addr_o     (wr_addr),
    .sts_i         (sts)
  );

  pte_dp #(
    .NUM_BINS (NUM_BINS),
    .MAX_DIMS (MAX_DIMS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .rd_addr_i    (rd_addr),
    .wr_addr_i    (wr_addr),
    .init_level_i (init_q),
    .dep_scale_i  (scale_q),
    .evap_i       (evap_q),
    .seed_i       (seed_q),
    .ant_fit_i    (s_axis_tdata[42:11]),
    .best_fit_i   (s_axis_tdata[74:43]),
    .sts_o        (sts)
  );

  assign m_axis_tdata = {2'b00, saturated, chosen_bin};

endmodule
